// ===== src/ubh_pkg.sv =====
// ubh_pkg: shared types and constants for the uniform bin histogram
// no dependencies

package ubh_pkg;

    localparam int CNT_W = 32;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // width of the bins register and of quotients from the divider
    localparam int NB_W = 7;

    localparam int ADDR_W = 4;
    localparam logic [ADDR_W-1:0] ADDR_LOWER = 4'h0;
    localparam logic [ADDR_W-1:0] ADDR_UPPER = 4'h4;
    localparam logic [ADDR_W-1:0] ADDR_BINS  = 4'h8;

endpackage

// ===== src/uniform_bin_histogram.sv =====
// uniform_bin_histogram: fixed-width bin histogram over signed samples
// a counted sample is accepted, passed through the bit-serial divider, then the counter ram
// is read and written back; one on the upper edge skips the divider; a skipped one is only accepted
// end of set sweeps all MAX_BINS entries, a read and a write each, plus a hold per emitted word
// reset runs the same sweep to zero the ram, with in_stall high
// depends on ubh_pkg, ubh_div, ubh_ram

module uniform_bin_histogram #(
    parameter int MAX_BINS    = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ubh_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample_value,
    input  logic                         has_sample,
    input  logic                         end_of_set,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [5:0]                   bin_number,
    output logic [ubh_pkg::CNT_W-1:0]    bin_total,
    output logic                         last_bin
);

    localparam int IW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int KW = (IW > ubh_pkg::NB_W) ? IW : ubh_pkg::NB_W;
    localparam int SW = SAMPLE_BITS + 1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV, ST_RD, ST_INC, ST_SRD, ST_SWR, ST_HOLD
    } state_t;

    state_t state_reg;

    logic signed [SAMPLE_BITS-1:0] lower_reg, upper_reg;
    logic [ubh_pkg::NB_W-1:0]      bins_reg;
    logic [IW-1:0]                 idx_reg, k_reg;
    logic                          eos_reg, emit_reg;
    logic                          out_valid_reg, last_reg;
    logic [5:0]                    num_reg;
    logic [ubh_pkg::CNT_W-1:0]     total_reg;

    logic [ubh_pkg::NB_W-1:0] n_act, n_m1, quot;
    logic                     cfg_ok, in_rng, on_top, count_it, div_start, div_done;
    logic [SW-1:0]            off, span;
    logic [KW-1:0]            k_ext;
    logic                     we, re;
    logic [IW-1:0]            waddr, raddr;
    logic [ubh_pkg::CNT_W-1:0] wdata, rdata;
    logic                     cfg_wr, k_emit, k_end;

    assign n_act  = ({25'b0, bins_reg} > 32'(MAX_BINS)) ? ubh_pkg::NB_W'(MAX_BINS) : bins_reg;
    assign n_m1   = n_act - 1'b1;
    assign cfg_ok = (upper_reg > lower_reg) && (n_act != '0);
    assign in_rng = (sample_value >= lower_reg) && (sample_value <= upper_reg);
    assign on_top = (sample_value == upper_reg);
    assign count_it = has_sample && cfg_ok && in_rng;
    assign off  = {sample_value[SAMPLE_BITS-1], sample_value}
                - {lower_reg[SAMPLE_BITS-1], lower_reg};
    assign span = {upper_reg[SAMPLE_BITS-1], upper_reg}
                - {lower_reg[SAMPLE_BITS-1], lower_reg};
    assign div_start = (state_reg == ST_IDLE) && in_valid && count_it && !on_top;

    assign k_ext  = KW'(k_reg);
    assign k_emit = emit_reg && (k_ext < KW'(n_act));
    assign k_end  = (k_reg == IW'(MAX_BINS - 1));
    assign cfg_wr = psel && penable && pwrite;

    ubh_div #(.SW(SW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .off   (off),
        .span  (span),
        .n     (n_act),
        .done  (div_done),
        .quot  (quot)
    );

    // read-modify-write never overlaps: the write lands before the next read
    always_comb
    begin
        re    = (state_reg == ST_RD) || (state_reg == ST_SRD);
        raddr = (state_reg == ST_RD) ? idx_reg : k_reg;
        we    = (state_reg == ST_INC) || (state_reg == ST_SWR);
        waddr = (state_reg == ST_INC) ? idx_reg : k_reg;
        wdata = '0;
        if (state_reg == ST_INC)
        begin
            wdata = (rdata == ubh_pkg::CNT_MAX) ? rdata : rdata + 1'b1;
        end
    end

    ubh_ram #(.DEPTH(MAX_BINS), .AW(IW)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SRD;
            k_reg         <= '0;
            emit_reg      <= 1'b0;
            eos_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            lower_reg     <= '0;
            upper_reg     <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            bins_reg      <= ubh_pkg::NB_W'(16);
        end
        else
        begin
            if (cfg_wr)
            begin
                case (paddr)
                    ubh_pkg::ADDR_LOWER: lower_reg <= pwdata[SAMPLE_BITS-1:0];
                    ubh_pkg::ADDR_UPPER: upper_reg <= pwdata[SAMPLE_BITS-1:0];
                    ubh_pkg::ADDR_BINS:  bins_reg  <= pwdata[ubh_pkg::NB_W-1:0];
                    default: ;
                endcase
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        eos_reg  <= end_of_set;
                        emit_reg <= end_of_set && cfg_ok;
                        k_reg    <= '0;
                        if (count_it && on_top)
                        begin
                            idx_reg   <= IW'(n_m1);
                            state_reg <= ST_RD;
                        end
                        else if (count_it)
                        begin
                            state_reg <= ST_DIV;
                        end
                        else if (end_of_set)
                        begin
                            state_reg <= ST_SRD;
                        end
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        idx_reg   <= (quot > n_m1) ? IW'(n_m1) : IW'(quot);
                        state_reg <= ST_RD;
                    end
                end
                ST_RD:
                begin
                    state_reg <= ST_INC;
                end
                ST_INC:
                begin
                    state_reg <= eos_reg ? ST_SRD : ST_IDLE;
                end
                ST_SRD:
                begin
                    state_reg <= ST_SWR;
                end
                ST_SWR:
                begin
                    if (k_emit)
                    begin
                        out_valid_reg <= 1'b1;
                        num_reg       <= k_ext[5:0];
                        total_reg     <= rdata;
                        last_reg      <= (k_ext == KW'(n_m1));
                        state_reg     <= ST_HOLD;
                    end
                    else if (k_end)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= ST_SRD;
                    end
                end
                ST_HOLD:
                begin
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        if (k_end)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= ST_SRD;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            ubh_pkg::ADDR_LOWER: prdata = 32'({1'b0, lower_reg} & {1'b0, {SAMPLE_BITS{1'b1}}});
            ubh_pkg::ADDR_UPPER: prdata = 32'({1'b0, upper_reg} & {1'b0, {SAMPLE_BITS{1'b1}}});
            ubh_pkg::ADDR_BINS:  prdata = 32'(bins_reg);
            default:             prdata = '0;
        endcase
    end

    assign pready     = 1'b1;
    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign bin_number = num_reg;
    assign bin_total  = total_reg;
    assign last_bin   = last_reg;

endmodule

// ===== src/ubh_ram.sv =====
// ubh_ram: bin counter store, one write port and one registered read port
// depends on ubh_pkg

module ubh_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                    clk,
    input  logic                    we,
    input  logic [AW-1:0]           waddr,
    input  logic [ubh_pkg::CNT_W-1:0] wdata,
    input  logic                    re,
    input  logic [AW-1:0]           raddr,
    output logic [ubh_pkg::CNT_W-1:0] rdata
);

    logic [ubh_pkg::CNT_W-1:0] mem [DEPTH];
    logic [ubh_pkg::CNT_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/ubh_div.sv =====
// ubh_div: bin index (off*n)/span, one quotient bit per cycle
// depends on ubh_pkg

module ubh_div #(
    parameter int SW = 17
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [SW-1:0]            off,
    input  logic [SW-1:0]            span,
    input  logic [ubh_pkg::NB_W-1:0] n,
    output logic                     done,
    output logic [ubh_pkg::NB_W-1:0] quot
);

    localparam int PW = SW + ubh_pkg::NB_W;
    localparam int JW = $clog2(ubh_pkg::NB_W);

    logic [PW-1:0]             rem_reg;
    logic [PW-1:0]             span_reg;
    logic [ubh_pkg::NB_W-1:0]  q_reg;
    logic [JW-1:0]             j_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic [PW-1:0]             dvs;

    assign dvs = span_reg << j_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            j_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= PW'(off) * PW'(n);
                span_reg <= PW'(span);
                q_reg    <= '0;
                j_reg    <= JW'(ubh_pkg::NB_W - 1);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (rem_reg >= dvs)
                begin
                    rem_reg      <= rem_reg - dvs;
                    q_reg[j_reg] <= 1'b1;
                end
                if (j_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    j_reg <= j_reg - 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// ===== src/ubh_checker.sv =====
// ubh_checker: port-level checks for uniform_bin_histogram, bound to the top
// depends on ubh_pkg

module ubh_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      pready,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic                      end_of_set,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic [5:0]                bin_number,
    input logic [ubh_pkg::CNT_W-1:0] bin_total
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(bin_number) && $stable(bin_total))
        else $error("stalled output word changed");

    // a pending word means the sweep is running, so input is held off
    a_busy_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while a word is pending");

    // an item that ends no set produces no word right after
    a_no_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !end_of_set |=> !out_valid)
        else $error("word emitted outside an end of set");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind uniform_bin_histogram ubh_checker u_ubh_checker (.*);
